// ===== design/vhtv_pkg.sv =====
`timescale 1ns / 1ps
package vhtv_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_DIM_X     = 3'd0;
    localparam logic [2:0] REG_DIM_Y     = 3'd1;
    localparam logic [2:0] REG_DIM_Z     = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_HALF_RECP = 3'd4;

    localparam int SUM_BITS   = 48;
    localparam int CFG_BITS   = 32;
    localparam int DIM_Z_MAX  = 4096;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LEFT,
        ST_UP,
        ST_PREV,
        ST_DONE
    } seq_state_t;

endpackage

// ===== design/vhtv_term.sv =====
`timescale 1ns / 1ps
// Huber term of one difference, one register stage.
module vhtv_term #(
    parameter int VALUE_BITS = 16
) (
    input  logic                          aclk,
    input  logic signed [VALUE_BITS-1:0]  cur_value,
    input  logic signed [VALUE_BITS-1:0]  nbr_value,
    input  logic [15:0]                   threshold,
    input  logic [31:0]                   half_recp,
    output logic [vhtv_pkg::SUM_BITS-1:0] term
);
    localparam int MAG_BITS = VALUE_BITS + 1;
    localparam int CMP_BITS = (MAG_BITS > 16) ? MAG_BITS : 16;

    logic signed [MAG_BITS-1:0] diff;
    logic [MAG_BITS-1:0]        mag;
    logic                       lin_next;
    logic                       lin_reg;
    logic [MAG_BITS-1:0]        mag_reg;
    logic [2*MAG_BITS-1:0]      sq_reg;
    logic [2*MAG_BITS+31:0]     prod;
    logic [MAG_BITS+1:0]        lin_term;

    // Magnitude and branch select, then square.
    always_comb begin
        diff     = MAG_BITS'(cur_value) - MAG_BITS'(nbr_value);
        mag      = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
        lin_next = (CMP_BITS'(mag) >= CMP_BITS'(threshold));
    end

    always_ff @(posedge aclk) begin
        lin_reg <= lin_next;
        mag_reg <= mag;
        sq_reg  <= mag * mag;
    end

    // Rounded linear term or rounded quadratic term.
    always_comb begin
        lin_term = (({1'b0, mag_reg, 1'b0} - (MAG_BITS+2)'(threshold)) + 1'b1) >> 1;
        prod     = sq_reg * half_recp;
        if (lin_reg) begin
            term = vhtv_pkg::SUM_BITS'(lin_term);
        end else begin
            term = vhtv_pkg::SUM_BITS'(((prod >> 31) + 1'b1) >> 1);
        end
    end
endmodule

// ===== design/volume_huber_total_variation.sv =====
`timescale 1ns / 1ps
// Result: m_valid rises after the last voxel of a volume has passed READ, LEFT, UP, PREV, DONE.
// Flow: accept in IDLE, store read in READ, LEFT, UP and PREV through the shared Huber
// unit, and DONE adds the last term; no new voxel is taken until IDLE. A total still
// waiting on the result port holds the last voxel of the next volume in DONE.
// Reset: synchronous, active low; positions, sum, state and configuration registers return to their
// reset values; row and plane memories are not cleared.
module volume_huber_total_variation #(
    parameter int MAX_DIM_X  = 256,
    parameter int MAX_DIM_Y  = 256,
    parameter int VALUE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [vhtv_pkg::CFG_BITS-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_BITS-1:0]  s_voxel_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vhtv_pkg::SUM_BITS-1:0] m_tv_total
);
    localparam int XB = $clog2(MAX_DIM_X);
    localparam int YB = $clog2(MAX_DIM_Y);
    localparam int ZB = $clog2(vhtv_pkg::DIM_Z_MAX);
    localparam int SB = vhtv_pkg::SUM_BITS;

    vhtv_pkg::seq_state_t state_reg, state_next;

    logic [8:0]  dim_x_reg, dim_y_reg;
    logic [12:0] dim_z_reg;
    logic [15:0] thr_reg;
    logic [31:0] recp_reg;
    logic [XB:0] dx;
    logic [YB:0] dy;
    logic [ZB:0] dz;

    logic [XB:0] pos_x_reg, pos_x_next;
    logic [YB:0] pos_y_reg, pos_y_next;
    logic [ZB:0] pos_z_reg, pos_z_next;
    logic [SB-1:0] sum_reg, sum_next, sum_acc;
    logic signed [VALUE_BITS-1:0] left_reg, left_next, cur_reg, nbr;
    logic signed [VALUE_BITS-1:0] row_mem [MAX_DIM_X];
    logic signed [VALUE_BITS-1:0] plane_mem [MAX_DIM_X*MAX_DIM_Y];
    logic signed [VALUE_BITS-1:0] row_rd_reg, plane_rd_reg;
    logic [XB-1:0]   px;
    logic [XB+YB-1:0] pidx;
    logic [SB-1:0]   term;
    logic [SB:0]     sum_add;
    logic            use_term;
    logic [2:0]      ten_reg;
    logic            last_x, last_y, last_z, tiny_volume;
    logic [SB-1:0]   out_reg;
    logic            out_valid_reg, out_valid_next;

    // Effective dimensions with clamping.
    always_comb begin
        dx = (dim_x_reg == 9'd0) ? (XB+1)'(1) :
             ({23'd0, dim_x_reg} > 32'(MAX_DIM_X)) ? (XB+1)'(MAX_DIM_X) :
             (XB+1)'(dim_x_reg);
        dy = (dim_y_reg == 9'd0) ? (YB+1)'(1) :
             ({23'd0, dim_y_reg} > 32'(MAX_DIM_Y)) ? (YB+1)'(MAX_DIM_Y) :
             (YB+1)'(dim_y_reg);
        dz = (dim_z_reg == 13'd0) ? (ZB+1)'(1) :
             (dim_z_reg > 13'(vhtv_pkg::DIM_Z_MAX)) ? (ZB+1)'(vhtv_pkg::DIM_Z_MAX) :
             (ZB+1)'(dim_z_reg);
        px   = pos_x_reg[XB-1:0];
        pidx = {pos_y_reg[YB-1:0], px};
        last_x = (pos_x_reg + 1'b1) == dx;
        last_y = (pos_y_reg + 1'b1) == dy;
        last_z = (pos_z_reg + 1'b1) == dz;
        tiny_volume = (dx < (XB+1)'(2)) || (dy < (YB+1)'(2)) || (dz < (ZB+1)'(2));
    end

    // Shared Huber unit; neighbor chosen by sequencer state.
    always_comb begin
        case (state_reg)
            vhtv_pkg::ST_LEFT: nbr = left_reg;
            vhtv_pkg::ST_UP:   nbr = row_rd_reg;
            default:           nbr = plane_rd_reg;
        endcase
    end

    vhtv_term #(.VALUE_BITS(VALUE_BITS)) u_term (
        .aclk      (aclk),
        .cur_value (cur_reg),
        .nbr_value (nbr),
        .threshold (thr_reg),
        .half_recp (recp_reg),
        .term      (term)
    );

    // Terms arrive in the state after the one that selects them: the LEFT term lands in UP, and so on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ten_reg <= '0;
        end else begin
            ten_reg <= {state_reg == vhtv_pkg::ST_PREV && pos_z_reg != '0,
                        state_reg == vhtv_pkg::ST_UP && pos_y_reg != '0,
                        state_reg == vhtv_pkg::ST_LEFT && pos_x_reg != '0};
        end
    end
    assign use_term = |ten_reg;
    assign sum_add  = {1'b0, sum_reg} + {1'b0, term};
    assign sum_acc  = use_term ? (sum_add[SB] ? {SB{1'b1}} : sum_add[SB-1:0]) : sum_reg;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vhtv_pkg::ST_IDLE: if (s_valid) state_next = vhtv_pkg::ST_READ;
            vhtv_pkg::ST_READ: state_next = vhtv_pkg::ST_LEFT;
            vhtv_pkg::ST_LEFT: state_next = vhtv_pkg::ST_UP;
            vhtv_pkg::ST_UP:   state_next = vhtv_pkg::ST_PREV;
            vhtv_pkg::ST_PREV: state_next = vhtv_pkg::ST_DONE;
            vhtv_pkg::ST_DONE: begin
                if (!(last_x && last_y && last_z) || !out_valid_reg || m_ready) begin
                    state_next = vhtv_pkg::ST_IDLE;
                end
            end
            default: state_next = vhtv_pkg::ST_IDLE;
        endcase
    end

    // Output logic.
    assign s_ready    = (state_reg == vhtv_pkg::ST_IDLE);
    assign m_valid    = out_valid_reg;
    assign m_tv_total = out_reg;

    // Position, sum and result flag updates; a register write restarts the volume.
    always_comb begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        sum_next       = sum_acc;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        if (m_valid && m_ready) out_valid_next = 1'b0;
        if (state_reg == vhtv_pkg::ST_DONE && state_next == vhtv_pkg::ST_IDLE) begin
            left_next = cur_reg;
            if (!last_x) begin
                pos_x_next = pos_x_reg + 1'b1;
            end else begin
                pos_x_next = '0;
                if (!last_y) begin
                    pos_y_next = pos_y_reg + 1'b1;
                end else begin
                    pos_y_next = '0;
                    if (!last_z) begin
                        pos_z_next = pos_z_reg + 1'b1;
                    end else begin
                        pos_z_next     = '0;
                        sum_next       = '0;
                        left_next      = '0;
                        out_valid_next = 1'b1;
                    end
                end
            end
        end
        if (cfg_we && cfg_index <= vhtv_pkg::REG_HALF_RECP) begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
            sum_next   = '0;
            left_next  = '0;
        end
    end

    // Memories: read in READ, write in PREV.
    always_ff @(posedge aclk) begin
        if (state_reg == vhtv_pkg::ST_READ) begin
            row_rd_reg   <= row_mem[px];
            plane_rd_reg <= plane_mem[pidx];
        end
        if (state_reg == vhtv_pkg::ST_PREV) begin
            row_mem[px]     <= cur_reg;
            plane_mem[pidx] <= cur_reg;
        end
        if (s_valid && s_ready) begin
            cur_reg <= s_voxel_value;
        end
        if (state_reg == vhtv_pkg::ST_DONE && last_x && last_y && last_z
            && (!out_valid_reg || m_ready)) begin
            out_reg <= tiny_volume ? '0 : sum_acc;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vhtv_pkg::ST_IDLE;
            dim_x_reg     <= 9'd1;
            dim_y_reg     <= 9'd1;
            dim_z_reg     <= 13'd1;
            thr_reg       <= 16'd4096;
            recp_reg      <= 32'd524288;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            sum_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_z_reg     <= pos_z_next;
            sum_reg       <= sum_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    vhtv_pkg::REG_DIM_X:     dim_x_reg <= cfg_wdata[8:0];
                    vhtv_pkg::REG_DIM_Y:     dim_y_reg <= cfg_wdata[8:0];
                    vhtv_pkg::REG_DIM_Z:     dim_z_reg <= cfg_wdata[12:0];
                    vhtv_pkg::REG_THRESHOLD: thr_reg   <= cfg_wdata[15:0];
                    vhtv_pkg::REG_HALF_RECP: recp_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end
endmodule
